@@ rtl/core/lcsl_pkg.sv @@
package lcsl_pkg;

    // Width of one string symbol.
    localparam int SYM_W = 8;

    // Default reference capacity and the run width that follows from it.
    localparam int DEF_MAX_LEN = 64;
    localparam int DEF_RUN_W   = $clog2(DEF_MAX_LEN + 1);

    // Operation codes carried in the opcode field of an input word.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control strobes broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;     // shift a reference symbol into the row
        logic restart;  // first symbol of a new reference
        logic query;    // compare a query symbol against the row
        logic last;     // the query symbol ends its string
        logic step;     // one step of the running-max reduction
        logic flush;    // result taken from the head cell, clear the maxima
    } ctl_t;

endpackage

@@ rtl/core/lcsl_if.sv @@
interface lcsl_in_if import lcsl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output opcode, output symbol, output last, input ready);
    modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

interface lcsl_out_if import lcsl_pkg::*; #(
    parameter int RUN_W = DEF_RUN_W
) ();
    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] max_common;

    modport source (output valid, output max_common, input ready);
    modport sink   (input valid, input max_common, output ready);
endinterface

@@ rtl/core/lcsl_cell.sv @@
module lcsl_cell import lcsl_pkg::*; #(
    parameter int RUN_W = DEF_RUN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  logic [SYM_W-1:0] query_sym,
    input  logic [SYM_W-1:0] load_sym,
    input  logic             load_vld,
    input  logic [RUN_W-1:0] run_up,
    input  logic [RUN_W-1:0] best_up,
    output logic [SYM_W-1:0] ref_sym,
    output logic             ref_vld,
    output logic [RUN_W-1:0] run,
    output logic [RUN_W-1:0] best
);

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             vld_reg;
    logic             vld_next;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic [RUN_W-1:0] best_reg;
    logic [RUN_W-1:0] best_next;
    logic             match;
    logic [RUN_W-1:0] run_new;

    // The cell above holds the preceding reference position, so its run
    // from the previous query symbol is the diagonal predecessor.
    assign match   = vld_reg && (sym_reg == query_sym);
    assign run_new = match ? (run_up + RUN_W'(1)) : '0;

    always_comb
    begin
        sym_next  = sym_reg;
        vld_next  = vld_reg;
        run_next  = run_reg;
        best_next = best_reg;
        if (ctl.load)
        begin
            sym_next = load_sym;
            vld_next = load_vld;
        end
        if (ctl.restart)
        begin
            run_next  = '0;
            best_next = '0;
        end
        if (ctl.query)
        begin
            run_next  = ctl.last ? '0 : run_new;
            best_next = (run_new > best_reg) ? run_new : best_reg;
        end
        if (ctl.step)
        begin
            best_next = (best_up > best_reg) ? best_up : best_reg;
        end
        if (ctl.flush)
        begin
            best_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            run_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            run_reg  <= run_next;
            best_reg <= best_next;
        end
    end

    assign ref_sym = sym_reg;
    assign ref_vld = vld_reg;
    assign run     = run_reg;
    assign best    = best_reg;

endmodule

@@ rtl/core/longest_common_substring_length.sv @@
// Reference load words and query words without last may follow back to back. A query word
// with last starts the fold of the maxima; its result moves to the output register when
// the fold is complete and that register is free, so it comes later while an earlier result
// is still held there; the input stays stalled until the result moves to that register.
// Throughput is one word per cycle while the input is not stalled.
// Reset clears the cell valid bits, runs, maxima, load flag, output register and
// sequencer; the stored reference symbols themselves are not reset.
module longest_common_substring_length import lcsl_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int RUN_W   = $clog2(MAX_LEN + 1)
) (
    input  logic       clk,
    input  logic       rst_n,
    lcsl_in_if.sink    item,
    lcsl_out_if.source result
);

    // The reference lives in a row of MAX_LEN cells. Each load word shifts
    // into cell 0 and pushes older symbols one cell up, so the first symbol
    // of the reference ends in the highest valid cell, and the predecessor
    // of every reference position sits in the cell just above it. Cells
    // above the reference hold no valid symbol and always carry a run of zero,
    // which also gives the first reference position its run of one.
    //
    // A query word is broadcast to all cells at once; each cell computes its
    // new run from its own symbol and the run of the cell above. Every cell
    // also keeps the largest run it has seen. After the last query word the
    // row folds those maxima downward until cell 0 holds the overall maximum,
    // which then moves to the output register.
    localparam int CNT_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LEN - 1);

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             loading_reg;
    logic             loading_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic [RUN_W-1:0] res_data_reg;
    logic [RUN_W-1:0] res_data_next;

    logic             accept;
    logic             is_load;
    logic             is_query;
    logic             full;
    logic             drain_done;
    ctl_t             ctl;

    logic [SYM_W-1:0] ref_sym  [MAX_LEN];
    logic             ref_vld  [MAX_LEN];
    logic [RUN_W-1:0] run      [MAX_LEN];
    logic [RUN_W-1:0] best     [MAX_LEN];

    // Input is taken only while the row is not folding its maxima.
    assign item.ready = (state_reg == ST_RUN);
    assign accept     = item.valid && item.ready;
    assign is_load    = accept && (item.opcode == OP_LOAD);
    assign is_query   = accept && (item.opcode == OP_QUERY);

    // The row is full once the top cell holds a symbol; further symbols of
    // the same reference are dropped.
    assign full = ref_vld[MAX_LEN-1];

    // The fold is complete when the counter reaches its end; the result is
    // handed over only when the output register is free.
    assign drain_done = (state_reg == ST_DRAIN) && (cnt_reg == CNT_LAST)
                        && (!res_valid_reg || result.ready);

    always_comb
    begin
        ctl.restart = is_load && !loading_reg;
        ctl.load    = is_load && (!loading_reg || !full);
        ctl.query   = is_query;
        ctl.last    = item.last;
        ctl.step    = (state_reg == ST_DRAIN) && (cnt_reg != CNT_LAST);
        ctl.flush   = drain_done;
    end

    genvar c;
    generate
        for (c = 0; c < MAX_LEN; c++)
        begin : g_cell
            logic [SYM_W-1:0] load_sym;
            logic             load_vld;
            logic [RUN_W-1:0] run_up;
            logic [RUN_W-1:0] best_up;

            if (c == 0)
            begin : g_head
                assign load_sym = item.symbol;
                assign load_vld = 1'b1;
            end
            else
            begin : g_body
                // A new reference invalidates everything behind the head.
                assign load_sym = ref_sym[c-1];
                assign load_vld = ref_vld[c-1] && !ctl.restart;
            end

            if (c == MAX_LEN - 1)
            begin : g_top
                assign run_up  = '0;
                assign best_up = '0;
            end
            else
            begin : g_inner
                assign run_up  = run[c+1];
                assign best_up = best[c+1];
            end

            lcsl_cell #(
                .RUN_W (RUN_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .query_sym (item.symbol),
                .load_sym  (load_sym),
                .load_vld  (load_vld),
                .run_up    (run_up),
                .best_up   (best_up),
                .ref_sym   (ref_sym[c]),
                .ref_vld   (ref_vld[c]),
                .run       (run[c]),
                .best      (best[c])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        loading_next   = loading_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        // A load word keeps the reference open until its last symbol; any
        // query word closes it.
        if (is_load)
        begin
            loading_next = !item.last;
        end
        if (is_query)
        begin
            loading_next = 1'b0;
        end

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (is_query && item.last)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (drain_done)
                begin
                    state_next     = ST_RUN;
                    res_valid_next = 1'b1;
                    res_data_next  = best[0];
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            loading_reg   <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loading_reg   <= loading_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.max_common = res_data_reg;

endmodule

@@ rtl/core/lcsl_chk.sv @@
module lcsl_chk import lcsl_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int RUN_W   = $clog2(MAX_LEN + 1)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             item_opcode,
    input logic             item_last,
    input logic             result_valid,
    input logic             result_ready,
    input logic [RUN_W-1:0] result_max_common
);

    // A stalled result word keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_max_common))
    else $error("result word changed while stalled");

    // A common substring can never be longer than the stored reference.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_max_common <= RUN_W'(MAX_LEN)))
    else $error("result exceeds reference capacity");

    // The end of a query starts the reduction, which stalls the input.
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_opcode == OP_QUERY) && item_last |=> !item_ready)
    else $error("input not stalled after the last query word");

    // A new result only appears at the end of a reduction, never while
    // input words are being taken.
    a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without a preceding reduction");

endmodule

bind longest_common_substring_length lcsl_chk #(
    .MAX_LEN (MAX_LEN),
    .RUN_W   (RUN_W)
) u_lcsl_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_opcode       (item.opcode),
    .item_last         (item.last),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_max_common (result.max_common)
);
